// ===== design/tlpt_pkg.sv =====
// Package for the two-level page table engine: transaction payload types,
// operation and status codes, and fixed field widths. No dependencies.
package tlpt_pkg;

   localparam int IDX_W     = 10;
   localparam int OFF_W     = 12;
   localparam int ADDR_W    = 32;
   localparam int DIR_DEPTH = 1024;
   localparam int DIR_FLAGS = 3;

   localparam logic [1:0] OP_MAP    = 2'd0;
   localparam logic [1:0] OP_UNMAP  = 2'd1;
   localparam logic [1:0] OP_XLATE  = 2'd2;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_NOT_MAP  = 2'd1;
   localparam logic [1:0] ST_NO_TABLE = 2'd2;

   localparam int POOL_TABLES_DEF = 16;

   typedef struct packed {
      logic [1:0]        op;
      logic [ADDR_W-1:0] virt_addr;
      logic [ADDR_W-1:0] phys_addr;
      logic [OFF_W-1:0]  page_flags;
   } req_type;

   typedef struct packed {
      logic [ADDR_W-1:0] phys_out;
      logic [OFF_W-1:0]  entry_bits;
      logic [1:0]        status;
   } rsp_type;

   typedef struct packed {
      logic             en;
      logic [IDX_W-1:0] addr;
   } dir_wr_type;

endpackage

// ===== design/tlpt_dir_mem.sv =====
// Page directory memory: 1024 entries of present, user, write and table number.
// Synchronous write, registered read. Depends on tlpt_pkg.
module tlpt_dir_mem
   import tlpt_pkg::*;
#(
   parameter int DATA_W = 7
) (
   input  logic              clock,
   input  dir_wr_type        wr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic [IDX_W-1:0]  rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [DIR_DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/tlpt_store_mem.sv =====
// Second-level table pool: POOL_TABLES tables of 1024 page entries each.
// Synchronous write, registered read. Depends on tlpt_pkg.
module tlpt_store_mem
   import tlpt_pkg::*;
#(
   parameter int POOL_TABLES = POOL_TABLES_DEF,
   parameter int SADDR_W     = 14
) (
   input  logic               clock,
   input  logic               wr_en,
   input  logic [SADDR_W-1:0] wr_addr,
   input  logic [ADDR_W-1:0]  wr_data,
   input  logic [SADDR_W-1:0] rd_addr,
   output logic [ADDR_W-1:0]  rd_data
);

   localparam int DEPTH = POOL_TABLES * DIR_DEPTH;

   logic [ADDR_W-1:0] mem [DEPTH];
   logic [ADDR_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/two_level_page_table_engine.sv =====
// Two-level page table engine: the control sequencer around the directory and
// table pool memories. Depends on tlpt_pkg, tlpt_dir_mem and tlpt_store_mem.
//
// Usage: one request transaction (map, unmap or translate) on the req_ channel
// produces exactly one response transaction on the rsp_ channel. Requests are
// handled one at a time; req_stall is low only while the sequencer is idle.
// A map over a present directory entry, an unmap, an unknown op, pool exhaustion
// and a translate under an absent directory entry finish after the directory
// read; a translate that hits a present directory entry also reads the table
// (directory read, then table read). A map that needs a new table first
// clears its 1024 entries, one per cycle, then writes the page entry. A new
// request is accepted only once the sequencer is back in idle, which it enters
// as the response is registered, so a request never overlaps the previous one.
// After reset the directory is swept to zero, one entry per cycle, with
// req_stall held high until the sweep ends. The response sits in an output
// register; while rsp_stall holds it, the next request is still accepted and
// its result waits in a hold register until the output register frees up.
module two_level_page_table_engine
   import tlpt_pkg::*;
#(
   parameter int POOL_TABLES = POOL_TABLES_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   localparam int TBL_W   = (POOL_TABLES > 1) ? $clog2(POOL_TABLES) : 1;
   localparam int CNT_W   = $clog2(POOL_TABLES + 1);
   localparam int DIR_W   = DIR_FLAGS + TBL_W;
   localparam int SADDR_W = TBL_W + IDX_W;

   localparam logic [2:0] S_INIT  = 3'd0;
   localparam logic [2:0] S_IDLE  = 3'd1;
   localparam logic [2:0] S_DIR   = 3'd2;
   localparam logic [2:0] S_CLEAR = 3'd3;
   localparam logic [2:0] S_MAP   = 3'd4;
   localparam logic [2:0] S_READ  = 3'd5;
   localparam logic [2:0] S_HOLD  = 3'd6;

   localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(DIR_DEPTH - 1);

   logic [2:0]       state_ff, state_in;
   logic [IDX_W-1:0] clr_ff, clr_in;
   logic [CNT_W-1:0] used_ff, used_in;
   logic [TBL_W-1:0] newtab_ff, newtab_in;
   req_type          req_ff, req_in;
   rsp_type          hold_ff, hold_in;
   rsp_type          rsp_ff, rsp_in;
   logic             rsp_valid_ff, rsp_valid_in;

   dir_wr_type         dir_wr;
   logic [DIR_W-1:0]   dir_wdata;
   logic [DIR_W-1:0]   dir_rd;
   logic               st_we;
   logic [SADDR_W-1:0] st_waddr;
   logic [ADDR_W-1:0]  st_wdata;
   logic [SADDR_W-1:0] st_raddr;
   logic [ADDR_W-1:0]  st_rd;

   logic             fin;
   rsp_type          fin_data;
   logic             slot_free;
   logic             dir_present;
   logic [IDX_W-1:0] page_idx;
   logic [ADDR_W-1:0] map_entry;

   tlpt_dir_mem #(
      .DATA_W(DIR_W)
   ) u_dir (
      .clock  (clock),
      .wr     (dir_wr),
      .wr_data(dir_wdata),
      .rd_addr(req_data.virt_addr[ADDR_W-1 -: IDX_W]),
      .rd_data(dir_rd)
   );

   tlpt_store_mem #(
      .POOL_TABLES(POOL_TABLES),
      .SADDR_W    (SADDR_W)
   ) u_store (
      .clock  (clock),
      .wr_en  (st_we),
      .wr_addr(st_waddr),
      .wr_data(st_wdata),
      .rd_addr(st_raddr),
      .rd_data(st_rd)
   );

   assign slot_free   = !rsp_valid_ff || !rsp_stall;
   assign dir_present = dir_rd[DIR_W-1];
   assign page_idx    = req_ff.virt_addr[OFF_W +: IDX_W];
   assign st_raddr    = {dir_rd[TBL_W-1:0], page_idx};
   assign map_entry   = {req_ff.phys_addr[ADDR_W-1:OFF_W], req_ff.page_flags | OFF_W'(1)};
   assign req_stall   = (state_ff != S_IDLE);

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      used_in      = used_ff;
      newtab_in    = newtab_ff;
      req_in       = req_ff;
      hold_in      = hold_ff;
      rsp_in       = rsp_ff;
      dir_wr.en    = 1'b0;
      dir_wr.addr  = req_ff.virt_addr[ADDR_W-1 -: IDX_W];
      dir_wdata    = '0;
      st_we        = 1'b0;
      st_waddr     = st_raddr;
      st_wdata     = '0;
      fin          = 1'b0;
      fin_data     = '0;

      case (state_ff)
         S_INIT: begin
            dir_wr.en   = 1'b1;
            dir_wr.addr = clr_ff;
            clr_in      = clr_ff + 1'b1;
            if (clr_ff == IDX_LAST) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               req_in   = req_data;
               state_in = S_DIR;
            end
         end
         S_DIR: begin
            case (req_ff.op)
               OP_MAP: begin
                  if (!dir_present) begin
                     if (used_ff == CNT_W'(POOL_TABLES)) begin
                        fin             = 1'b1;
                        fin_data.status = ST_NO_TABLE;
                     end else begin
                        // Claim the next pool table, then clear it before use.
                        dir_wr.en = 1'b1;
                        dir_wdata = {1'b1, req_ff.page_flags[2], 1'b1,
                                     used_ff[TBL_W-1:0]};
                        used_in   = used_ff + 1'b1;
                        newtab_in = used_ff[TBL_W-1:0];
                        state_in  = S_CLEAR;
                     end
                  end else begin
                     st_we    = 1'b1;
                     st_wdata = map_entry;
                     fin      = 1'b1;
                  end
               end
               OP_UNMAP: begin
                  fin = 1'b1;
                  if (dir_present) begin
                     st_we = 1'b1;
                  end else begin
                     fin_data.status = ST_NOT_MAP;
                  end
               end
               OP_XLATE: begin
                  if (dir_present) begin
                     state_in = S_READ;
                  end else begin
                     fin             = 1'b1;
                     fin_data.status = ST_NOT_MAP;
                  end
               end
               default: begin
                  fin = 1'b1;
               end
            endcase
         end
         S_CLEAR: begin
            st_we    = 1'b1;
            st_waddr = {newtab_ff, clr_ff};
            clr_in   = clr_ff + 1'b1;
            if (clr_ff == IDX_LAST) begin
               state_in = S_MAP;
            end
         end
         S_MAP: begin
            st_we    = 1'b1;
            st_waddr = {newtab_ff, page_idx};
            st_wdata = map_entry;
            fin      = 1'b1;
         end
         S_READ: begin
            fin = 1'b1;
            if (st_rd[0]) begin
               fin_data.phys_out   = {st_rd[ADDR_W-1:OFF_W], req_ff.virt_addr[OFF_W-1:0]};
               fin_data.entry_bits = st_rd[OFF_W-1:0];
            end else begin
               fin_data.status = ST_NOT_MAP;
            end
         end
         S_HOLD: begin
            fin      = 1'b1;
            fin_data = hold_ff;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // A finished result goes straight to the output register when it is
      // free, and otherwise parks in the hold register.
      if (fin) begin
         if (slot_free) begin
            rsp_in   = fin_data;
            state_in = S_IDLE;
         end else begin
            hold_in  = fin_data;
            state_in = S_HOLD;
         end
      end
      rsp_valid_in = (rsp_valid_ff && rsp_stall) || (fin && slot_free);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         clr_ff       <= '0;
         used_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         used_ff      <= used_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      newtab_ff <= newtab_in;
      req_ff    <= req_in;
      hold_ff   <= hold_in;
      rsp_ff    <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_pool_bound: assert property (@(posedge clock) disable iff (reset)
      used_ff <= CNT_W'(POOL_TABLES))
      else $error("table pool count exceeds pool size");

   a_accept_to_dir: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff == S_DIR))
      else $error("accepted transaction did not start a directory lookup");

   a_read_after_dir: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_READ) |-> ($past(state_ff) == S_DIR))
      else $error("table read without a preceding directory lookup");

   a_map_after_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_MAP) |-> ($past(state_ff) == S_CLEAR && $past(clr_ff) == IDX_LAST))
      else $error("new table written before its clear finished");

endmodule

// ===== dv/tlpt_checker.sv =====
`timescale 1ns / 100ps
// Checker for the two-level page table engine: watches both channels, walks its
// own copy of the directory and table pool, and compares every response.
// Depends on tlpt_pkg for the payload types and the operation and status codes.
module tlpt_checker
   import tlpt_pkg::*;
#(
   parameter int POOL_TABLES = POOL_TABLES_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_stall,
   input  req_type req_data,
   input  logic    rsp_valid,
   input  logic    rsp_stall,
   input  rsp_type rsp_data,
   output int      error_count,
   output int      pending_results
);

   localparam logic [OFF_W-1:0] PRESENT_BIT = 12'h001;
   localparam int REPORT_LIMIT = 10;

   logic               dir_present [DIR_DEPTH];
   int                 dir_table   [DIR_DEPTH];
   logic [ADDR_W-1:0]  page_entry  [POOL_TABLES*DIR_DEPTH];
   int                 tables_taken;
   rsp_type            walk_results[$];
   int                 mismatches;

   // Applies one request to the shadow tables and returns the response it should get.
   function automatic rsp_type walk_tables(input req_type r);
      logic [IDX_W-1:0]  dir_idx;
      logic [IDX_W-1:0]  pg_idx;
      int                slot;
      logic [ADDR_W-1:0] entry;
      rsp_type           res;
      res     = '0;
      dir_idx = r.virt_addr[31:22];
      pg_idx  = r.virt_addr[21:12];
      case (r.op)
         OP_MAP: begin
            if (!dir_present[dir_idx]) begin
               if (tables_taken >= POOL_TABLES) begin
                  res.status = ST_NO_TABLE;
               end else begin
                  for (int i = 0; i < DIR_DEPTH; i++)
                     page_entry[tables_taken*DIR_DEPTH + i] = '0;
                  dir_table[dir_idx]   = tables_taken;
                  dir_present[dir_idx] = 1'b1;
                  tables_taken++;
               end
            end
            if (res.status == ST_OK) begin
               slot = dir_table[dir_idx]*DIR_DEPTH + pg_idx;
               page_entry[slot] = {r.phys_addr[31:12], r.page_flags | PRESENT_BIT};
            end
         end
         OP_UNMAP: begin
            if (!dir_present[dir_idx])
               res.status = ST_NOT_MAP;
            else
               page_entry[dir_table[dir_idx]*DIR_DEPTH + pg_idx] = '0;
         end
         OP_XLATE: begin
            if (!dir_present[dir_idx]) begin
               res.status = ST_NOT_MAP;
            end else begin
               entry = page_entry[dir_table[dir_idx]*DIR_DEPTH + pg_idx];
               if ((entry[OFF_W-1:0] & PRESENT_BIT) == '0) begin
                  res.status = ST_NOT_MAP;
               end else begin
                  res.phys_out   = {entry[31:12], r.virt_addr[11:0]};
                  res.entry_bits = entry[OFF_W-1:0];
               end
            end
         end
         default: ;
      endcase
      return res;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         for (int i = 0; i < DIR_DEPTH; i++) begin
            dir_present[i] = 1'b0;
            dir_table[i]   = 0;
         end
         tables_taken = 0;
         mismatches   = 0;
         walk_results.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (walk_results.size() == 0) begin
               mismatches++;
               if (mismatches <= REPORT_LIMIT)
                  $display("Unexpected response transaction: phys_out %h entry_bits %h status %0d",
                           rsp_data.phys_out, rsp_data.entry_bits, rsp_data.status);
            end else begin
               want = walk_results.pop_front();
               if (rsp_data.phys_out !== want.phys_out ||
                   rsp_data.entry_bits !== want.entry_bits ||
                   rsp_data.status !== want.status) begin
                  mismatches++;
                  if (mismatches <= REPORT_LIMIT)
                     $display("Response mismatch: expected %h/%h/%0d, got %h/%h/%0d",
                              want.phys_out, want.entry_bits, want.status,
                              rsp_data.phys_out, rsp_data.entry_bits, rsp_data.status);
               end
            end
         end
         if (req_valid && !req_stall)
            walk_results.push_back(walk_tables(req_data));
      end
      error_count     <= mismatches;
      pending_results <= walk_results.size();
   end

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps
// Top of the page table engine testbench: clock, reset, request and response
// stimulus and the final verdict. Depends on tlpt_pkg, tlpt_checker and the engine.
module testbench
   import tlpt_pkg::*;
();

   localparam logic [1:0] OP_UNKNOWN = 2'd3;
   localparam int RANDOM_ITEMS = 1400;
   localparam int QUIET_TAIL   = 200;
   localparam int LONG_HOLD    = 300;
   localparam int CYCLE_LIMIT  = 400000;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   req_type req_data  = '0;
   logic    rsp_stall = 1'b0;
   logic    req_stall;
   logic    rsp_valid;
   rsp_type rsp_data;
   int      error_count;
   int      pending_results;

   int      sent_count  = 0;
   int      cycle_count = 0;
   bit      idle_on     = 1'b0;
   bit      long_hold_done = 1'b0;

   logic [IDX_W-1:0]  dir_pick [24];
   logic [IDX_W-1:0]  page_pick[16];
   logic [ADDR_W-1:0] mapped_pages[$];

   two_level_page_table_engine i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   tlpt_checker i_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_data        (req_data),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_data        (rsp_data),
      .error_count     (error_count),
      .pending_results (pending_results)
   );

   always #10 clock = ~clock;

   function automatic req_type make_req(input logic [1:0] op, input logic [31:0] virt,
                                        input logic [31:0] phys, input logic [11:0] flags);
      req_type r;
      r.op         = op;
      r.virt_addr  = virt;
      r.phys_addr  = phys;
      r.page_flags = flags;
      return r;
   endfunction

   function automatic int pick_gap();
      if (idle_on && $urandom_range(0, 99) < 30)
         return $urandom_range(1, 5);
      return 0;
   endfunction

   // Most addresses land on a small set of directory and page indexes so that
   // translations hit mapped pages; the rest are fully random.
   function automatic req_type random_request();
      req_type           r;
      int                pick;
      logic [ADDR_W-1:0] v;
      r.phys_addr  = $urandom;
      r.page_flags = OFF_W'($urandom_range(0, 4095));
      pick = $urandom_range(0, 99);
      if (pick < 35)
         r.op = OP_MAP;
      else if (pick < 50)
         r.op = OP_UNMAP;
      else if (pick < 95)
         r.op = OP_XLATE;
      else
         r.op = OP_UNKNOWN;
      if ($urandom_range(0, 99) < 12)
         v = $urandom;
      else if (r.op != OP_MAP && mapped_pages.size() > 0 && $urandom_range(0, 1) == 1)
         v = mapped_pages[$urandom_range(0, mapped_pages.size() - 1)];
      else
         v = {dir_pick[$urandom_range(0, 23)], page_pick[$urandom_range(0, 15)], 12'h000};
      v[11:0] = OFF_W'($urandom_range(0, 4095));
      r.virt_addr = v;
      if (r.op == OP_MAP) begin
         mapped_pages.push_back(v);
         if (mapped_pages.size() > 64)
            void'(mapped_pages.pop_front());
      end
      return r;
   endfunction

   // Offers one transaction after an optional idle gap and returns once it is accepted.
   // Valid is left high so that a following transaction can go out back to back.
   task automatic send_req(input req_type r, input int gap);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sent_count++;
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_results != 0);
   endtask

   // Response side: short random stalls, and once a long hold that backs the
   // engine up until it refuses new requests.
   initial begin
      forever begin
         @(posedge clock);
         if (!long_hold_done && sent_count >= 400) begin
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD) @(posedge clock);
            rsp_stall <= 1'b0;
            long_hold_done = 1'b1;
         end else if (idle_on && $urandom_range(0, 99) < 15) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 5)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      dir_pick[0]  = 10'd0;
      dir_pick[23] = 10'd1023;
      for (int i = 1; i < 23; i++)
         dir_pick[i] = IDX_W'(i*42 + $urandom_range(1, 40));
      foreach (page_pick[i])
         page_pick[i] = IDX_W'($urandom_range(0, 1023));

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed part: empty tables, extreme fields, overwrite, unmap and unknown op.
      send_req(make_req(OP_XLATE, 32'h0000_0000, 32'h0, 12'h000), 0);
      send_req(make_req(OP_UNMAP, 32'h0000_0000, 32'h0, 12'h000), 0);
      send_req(make_req(OP_MAP, 32'h0000_0000, 32'hFFFF_FABC, 12'hFFF), 0);
      send_req(make_req(OP_XLATE, 32'h0000_0FFF, 32'h0, 12'h000), 0);
      send_req(make_req(OP_MAP, 32'hFFFF_FFFF, 32'h0000_0FFF, 12'h000), 0);
      send_req(make_req(OP_XLATE, 32'hFFFF_F000, 32'hFFFF_FFFF, 12'hFFF), 0);
      send_req(make_req(OP_XLATE, 32'hFFBF_F123, 32'h0, 12'h000), 0);
      send_req(make_req(OP_XLATE, 32'h0000_1000, 32'h0, 12'h000), 0);
      send_req(make_req(OP_MAP, 32'h0000_0555, 32'h1234_5000, 12'h004), 0);
      send_req(make_req(OP_XLATE, 32'h0000_0ABC, 32'h0, 12'h000), 0);
      send_req(make_req(OP_UNMAP, 32'h0000_0FFF, 32'hFFFF_FFFF, 12'hFFF), 0);
      send_req(make_req(OP_XLATE, 32'h0000_0000, 32'h0, 12'h000), 0);
      send_req(make_req(OP_UNMAP, 32'h0000_1000, 32'h0, 12'h000), 0);
      send_req(make_req(OP_UNKNOWN, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 12'hFFF), 0);
      send_req(make_req(OP_MAP, 32'h0040_0000, 32'h8000_0000, 12'h0FE), 0);
      send_req(make_req(OP_XLATE, 32'h0040_0FFF, 32'h0, 12'h000), 0);
      send_req(make_req(OP_UNMAP, 32'hFFFF_F000, 32'h0, 12'h000), 0);
      send_req(make_req(OP_XLATE, 32'hFFFF_FFFF, 32'h0, 12'h000), 0);
      drain_results();

      // One map per hot directory index; there are more of them than pool
      // tables, so the later ones find the pool exhausted.
      foreach (dir_pick[i])
         send_req(make_req(OP_MAP, {dir_pick[i], page_pick[i % 16], 12'($urandom)},
                           $urandom, 12'($urandom)), pick_gap());

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         idle_on = (n < RANDOM_ITEMS - QUIET_TAIL) && ((n / 150) % 2 == 0);
         if (n == 700)
            drain_results();
         send_req(random_request(), pick_gap());
      end

      drain_results();
      repeat (20) @(posedge clock);
      if (error_count == 0 && pending_results == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
